[hdl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths and codes of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int PIX_W      = 8;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 10;
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;
	localparam int SUM_W      = 10;
	localparam int SQ_W       = 21;
	localparam int ROOT_W     = 11;

	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;
	localparam int MIN_SIDE         = 3;
	localparam int MAG_MAX          = 255;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

[hdl/sem_if.sv]
// ----------------------------------------------------------------------------
// sem_if
// Channels of the Sobel edge magnitude block: pixel in, result out, config.
// ----------------------------------------------------------------------------
interface sem_pix_if;
	logic          valid;
	logic          ready;
	sem_pkg::pix_t pixel_in;
	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface sem_res_if;
	logic                     valid;
	logic                     ready;
	logic [sem_pkg::ROW_W-1:0] out_row;
	logic [sem_pkg::COL_W-1:0] out_col;
	sem_pkg::pix_t            out_pixel;
	logic                     frame_last;
	modport source (output valid, output out_row, output out_col, output out_pixel,
		output frame_last, input ready);
	modport sink (input valid, input out_row, input out_col, input out_pixel,
		input frame_last, output ready);
endinterface

interface sem_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sem_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [sem_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output reg_index, output data, input ready);
	modport sink (input valid, input reg_index, input data, output ready);
endinterface

[hdl/sobel_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 Sobel edge magnitude over a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. On acceptance both line memories are read at
// the pixel's column; the next cycle builds the Sobel sums from the read data
// and the window registers, writes the column back and advances the counters.
// A pixel that completes an interior output then passes through the squaring
// state and waits on the iterative square root (eleven steps of two radicand
// bits each, then the root is handed over from a done register); a pixel whose
// results are all border pass-throughs goes straight to emitting, and a pixel
// of row 0 gives no results. No new pixel is taken until every result of the
// current one is in the output register. Each pixel gives 0 to 4 results;
// near the last row they leave out of raster order, so each carries its row
// and column, and the bottom-right result has frame_last set. Results go
// through an output register, so the next pixel is taken while the last
// result still waits. A write to either frame register restarts the frame;
// write config only while the block is idle.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	sem_cfg_if.sink   cfg,
	sem_pix_if.sink   pix,
	sem_res_if.source res
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int OW = (AW > sem_pkg::COL_W) ? AW : sem_pkg::COL_W;
	localparam int RST_LAST_COL =
		((sem_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : sem_pkg::FRAME_WIDTH_RST) - 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_ROOT = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	typedef logic [sem_pkg::SUM_W-1:0] sum_t;

	logic [2:0]                state_q;
	logic [sem_pkg::ROW_W-1:0] last_row_q;
	logic [AW-1:0]             last_col_q;
	logic [sem_pkg::ROW_W-1:0] row_q;
	logic [AW-1:0]             col_q;
	sem_pkg::pix_t             win_q [6];

	// line memories
	sem_pkg::pix_t line_above_mem     [MAX_WIDTH];
	sem_pkg::pix_t line_two_above_mem [MAX_WIDTH];
	sem_pkg::pix_t mid_rd_q;
	sem_pkg::pix_t top_rd_q;

	// snapshot of the item at work
	sem_pkg::pix_t             bot_q;
	logic [sem_pkg::ROW_W-1:0] snap_row_q;
	logic [AW-1:0]             snap_col_q;
	sem_pkg::pix_t             snap_mid_q;
	sem_pkg::pix_t             snap_w5_q;
	sem_pkg::pix_t             val0_q;
	sum_t                      a_q;
	sum_t                      b_q;
	logic [3:0]                pend_q;

	// output register
	logic                      out_valid_q;
	logic [sem_pkg::ROW_W-1:0] out_row_q;
	logic [sem_pkg::COL_W-1:0] out_col_q;
	sem_pkg::pix_t             out_pixel_q;
	logic                      out_last_q;

	logic accept;
	logic cfg_wr;
	logic load_out;

	sum_t right_sum, left_sum, lower_sum, upper_sum;
	sum_t a_abs, b_abs;
	logic interior;
	logic [3:0] pend_new;

	logic [sem_pkg::SQ_W-1:0]   sq_sum;
	logic                       root_done;
	logic [sem_pkg::ROOT_W-1:0] root;
	logic [sem_pkg::ROOT_W-3:0] mag;

	logic [3:0]                sel;
	logic [sem_pkg::ROW_W-1:0] sel_row;
	logic [AW-1:0]             sel_col;
	sem_pkg::pix_t             sel_pix;
	logic                      sel_last;
	logic [OW-1:0]             sel_col_ext;

	logic [31:0] fw_lim;
	logic [31:0] fh_lim;

	assign accept   = pix.valid && pix.ready;
	assign cfg_wr   = cfg.valid && cfg.ready;
	assign pix.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// clamp written sizes to the supported range
	always_comb begin
		fw_lim = 32'(cfg.data[sem_pkg::FW_W-1:0]);
		if (fw_lim < 32'(sem_pkg::MIN_SIDE)) begin
			fw_lim = 32'(sem_pkg::MIN_SIDE);
		end
		if (fw_lim > 32'(MAX_WIDTH)) begin
			fw_lim = 32'(MAX_WIDTH);
		end
		fw_lim = fw_lim - 32'd1;
		fh_lim = 32'(cfg.data[sem_pkg::FH_W-1:0]);
		if (fh_lim < 32'(sem_pkg::MIN_SIDE)) begin
			fh_lim = 32'(sem_pkg::MIN_SIDE);
		end
		fh_lim = fh_lim - 32'd1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mid_rd_q <= line_above_mem[col_q];
			top_rd_q <= line_two_above_mem[col_q];
		end
		if (state_q == S_READ) begin
			line_above_mem[col_q]     <= bot_q;
			line_two_above_mem[col_q] <= mid_rd_q;
		end
	end

	// Sobel sums: column c-2 in win 0..2, column c-1 in win 3..5, column c
	// from the line memories and the arriving pixel
	always_comb begin
		right_sum = sum_t'(top_rd_q) + (sum_t'(mid_rd_q) << 1) + sum_t'(bot_q);
		left_sum  = sum_t'(win_q[0]) + (sum_t'(win_q[1]) << 1) + sum_t'(win_q[2]);
		lower_sum = sum_t'(win_q[2]) + (sum_t'(win_q[5]) << 1) + sum_t'(bot_q);
		upper_sum = sum_t'(win_q[0]) + (sum_t'(win_q[3]) << 1) + sum_t'(top_rd_q);
		a_abs = (right_sum > left_sum) ? right_sum - left_sum : left_sum - right_sum;
		b_abs = (lower_sum > upper_sum) ? lower_sum - upper_sum : upper_sum - lower_sum;
		interior = (row_q >= sem_pkg::ROW_W'(2)) && (col_q >= AW'(2)) && (col_q <= last_col_q);
		pend_new[0] = (row_q != '0) && (col_q != '0);
		pend_new[1] = (row_q != '0) && (col_q == last_col_q);
		pend_new[2] = (row_q == last_row_q) && (col_q != '0);
		pend_new[3] = (row_q == last_row_q) && (col_q == last_col_q);
	end

	assign sq_sum = sem_pkg::SQ_W'(a_q) * sem_pkg::SQ_W'(a_q)
		+ sem_pkg::SQ_W'(b_q) * sem_pkg::SQ_W'(b_q);

	sem_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SQ),
		.radicand (sq_sum),
		.done     (root_done),
		.root     (root)
	);

	assign mag = root[sem_pkg::ROOT_W-1:2];

	// pick the next pending result in emission order
	always_comb begin
		sel      = '0;
		sel_row  = snap_row_q;
		sel_col  = snap_col_q;
		sel_pix  = bot_q;
		sel_last = 1'b0;
		priority if (pend_q[0]) begin
			sel     = 4'b0001;
			sel_row = snap_row_q - sem_pkg::ROW_W'(1);
			sel_col = snap_col_q - AW'(1);
			sel_pix = val0_q;
		end else if (pend_q[1]) begin
			sel     = 4'b0010;
			sel_row = snap_row_q - sem_pkg::ROW_W'(1);
			sel_pix = snap_mid_q;
		end else if (pend_q[2]) begin
			sel     = 4'b0100;
			sel_col = snap_col_q - AW'(1);
			sel_pix = snap_w5_q;
		end else if (pend_q[3]) begin
			sel      = 4'b1000;
			sel_last = 1'b1;
		end else begin
			sel = '0;
		end
		sel_col_ext = OW'(sel_col);
	end

	assign load_out = (state_q == S_EMIT) && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_row_q  <= sem_pkg::ROW_W'(sem_pkg::FRAME_HEIGHT_RST - 1);
			last_col_q  <= AW'(RST_LAST_COL);
			row_q       <= '0;
			col_q       <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				// any known register restarts the frame; others are dropped
				if (cfg.reg_index == sem_pkg::CFG_FRAME_WIDTH) begin
					last_col_q <= fw_lim[AW-1:0];
					row_q      <= '0;
					col_q      <= '0;
				end else if (cfg.reg_index == sem_pkg::CFG_FRAME_HEIGHT) begin
					last_row_q <= fh_lim[sem_pkg::ROW_W-1:0];
					row_q      <= '0;
					col_q      <= '0;
				end
			end

			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out && sel != '0) begin
				out_valid_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					pend_q   <= pend_new;
					win_q[0] <= win_q[3];
					win_q[1] <= win_q[4];
					win_q[2] <= win_q[5];
					win_q[3] <= top_rd_q;
					win_q[4] <= mid_rd_q;
					win_q[5] <= bot_q;
					// advance position, wrap at the frame edges
					if (col_q >= last_col_q) begin
						col_q <= '0;
						row_q <= (row_q >= last_row_q) ? '0 : row_q + sem_pkg::ROW_W'(1);
					end else begin
						col_q <= col_q + AW'(1);
					end
					if (interior) begin
						state_q <= S_SQ;
					end else if (pend_new != '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SQ: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load_out) begin
						pend_q <= pend_q & ~sel;
						if ((pend_q & ~sel) == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload of the item at work
	always_ff @(posedge clk) begin
		if (accept) begin
			bot_q <= pix.pixel_in;
		end
		if (state_q == S_READ) begin
			snap_row_q <= row_q;
			snap_col_q <= col_q;
			snap_mid_q <= mid_rd_q;
			snap_w5_q  <= win_q[5];
			val0_q     <= win_q[4];
			a_q        <= a_abs;
			b_q        <= b_abs;
		end
		if (state_q == S_ROOT && root_done) begin
			val0_q <= (mag > ($bits(mag))'(sem_pkg::MAG_MAX))
				? sem_pkg::pix_t'(sem_pkg::MAG_MAX) : mag[sem_pkg::PIX_W-1:0];
		end
		if (load_out) begin
			out_row_q   <= sel_row;
			out_col_q   <= sel_col_ext[sem_pkg::COL_W-1:0];
			out_pixel_q <= sel_pix;
			out_last_q  <= sel_last;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_row    = out_row_q;
	assign res.out_col    = out_col_q;
	assign res.out_pixel  = out_pixel_q;
	assign res.frame_last = out_last_q;

	// taking a pixel means every result of the previous one is out of the queue
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pix.ready |-> pend_q == '0)
		else $error("pixel taken with results pending");

	a_root_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == S_ROOT)
		else $error("square root finished outside its wait state");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col_q && row_q <= last_row_q)
		else $error("position counter outside the frame");

	a_last_on_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_last |-> res.out_row == last_row_q)
		else $error("frame end marked off the last row");

endmodule

[hdl/sem_isqrt.sv]
// ----------------------------------------------------------------------------
// sem_isqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module sem_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sem_pkg::SQ_W-1:0]   radicand,
	output logic                       done,
	output logic [sem_pkg::ROOT_W-1:0] root
);

	localparam int RW = sem_pkg::SQ_W + 1;
	localparam int TOP_BIT = ((sem_pkg::SQ_W - 1) / 2) * 2;

	logic          busy_q;
	logic          done_q;
	logic [RW-1:0] v_q;
	logic [RW-1:0] res_q;
	logic [RW-1:0] bit_q;
	logic [RW-1:0] trial;
	logic [RW-1:0] v_next;
	logic [RW-1:0] res_next;

	always_comb begin
		trial = res_q + bit_q;
		if (v_q >= trial) begin
			v_next   = v_q - trial;
			res_next = (res_q >> 1) + bit_q;
		end else begin
			v_next   = v_q;
			res_next = res_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == RW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= RW'(radicand);
			res_q <= '0;
			bit_q <= RW'(1) << TOP_BIT;
		end else if (busy_q) begin
			v_q   <= v_next;
			res_q <= res_next;
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[sem_pkg::ROOT_W-1:0];

endmodule
